@@ hdl/swd_pkg.sv @@
// ----------------------------------------------------------------------------
// swd_pkg: shared types and constants for the stopwatch
// Digit positions, count limits, the seven-segment font and the structs
// that travel between the key, timer and display blocks.
// ----------------------------------------------------------------------------
package swd_pkg;

   // display geometry
   localparam int DIGIT_COUNT = 8;
   localparam int SCAN_W      = 3;

   // digit positions on the display
   localparam logic [SCAN_W-1:0] POS_BLANK_0  = 3'd0;
   localparam logic [SCAN_W-1:0] POS_BLANK_1  = 3'd1;
   localparam logic [SCAN_W-1:0] POS_SEC_THOU = 3'd2;
   localparam logic [SCAN_W-1:0] POS_SEC_HUND = 3'd3;
   localparam logic [SCAN_W-1:0] POS_SEC_TENS = 3'd4;
   localparam logic [SCAN_W-1:0] POS_SEC_ONES = 3'd5;
   localparam logic [SCAN_W-1:0] POS_FRAC_TEN = 3'd6;
   localparam logic [SCAN_W-1:0] POS_FRAC_ONE = 3'd7;

   // count limits and reset values
   localparam logic [6:0]  FRAC_LAST  = 7'd99;
   localparam logic [13:0] SEC_LAST   = 14'd9999;
   localparam logic [3:0]  BCD_NINE   = 4'd9;
   localparam logic [7:0]  TPH_RESET  = 8'd5;
   localparam logic [7:0]  SEG_DP     = 8'h80;
   localparam logic [7:0]  SEG_BLANK  = 8'h00;

   typedef logic [3:0] bcd_type;

   // debounced press edges of one tick
   typedef struct packed {
      logic reset_press;
      logic toggle_press;
   } keys_type;

   // stopwatch count, binary and decimal digit forms kept in step
   typedef struct packed {
      logic              run;
      logic [6:0]        frac;
      logic [13:0]       sec;
      bcd_type [1:0]     frac_bcd;   // [1] tens, [0] ones
      bcd_type [3:0]     sec_bcd;    // [3] thousands .. [0] ones
   } count_type;

   // seven-segment font, bit 7 is the decimal point
   function automatic logic [7:0] font(input bcd_type d);
      logic [7:0] s;
      case (d)
         4'd0:    s = 8'h3F;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5B;
         4'd3:    s = 8'h4F;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6D;
         4'd6:    s = 8'h7D;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7F;
         4'd9:    s = 8'h6F;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

endpackage

@@ hdl/swd_interfaces.sv @@
// ----------------------------------------------------------------------------
// swd_interfaces: valid/ready channels of the stopwatch
// Key sample channel, display/count result channel and prescale write port.
// ----------------------------------------------------------------------------
interface swd_req_if;
   logic valid;
   logic ready;
   logic key_reset_raw;
   logic key_startstop_raw;

   modport source (output valid, output key_reset_raw, output key_startstop_raw,
                   input ready);
   modport sink   (input valid, input key_reset_raw, input key_startstop_raw,
                   output ready);
endinterface

interface swd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  digit_select_n;
   logic [7:0]  segments;
   logic        running;
   logic [6:0]  hundredths;
   logic [13:0] seconds;

   modport source (output valid, output digit_select_n, output segments,
                   output running, output hundredths, output seconds,
                   input ready);
   modport sink   (input valid, input digit_select_n, input segments,
                   input running, input hundredths, input seconds,
                   output ready);
endinterface

interface swd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] ticks_per_hundredth;

   modport source (output valid, output ticks_per_hundredth, input ready);
   modport sink   (input valid, input ticks_per_hundredth, output ready);
endinterface

@@ hdl/swd_debounce.sv @@
// ----------------------------------------------------------------------------
// swd_debounce: one key's sample history and debounced level
// The level changes only when the whole history agrees; a falling
// debounced level is reported as a press for the current beat.
// ----------------------------------------------------------------------------
module swd_debounce #(
   parameter int HISTORY_LEN = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic enable,
   input  logic level,
   output logic press
);

   logic [HISTORY_LEN-1:0] hist_ff, hist_in;
   logic                   deb_ff, deb_in;

   // shift in the new sample, settle on full agreement
   always_comb begin
      hist_in = {hist_ff[HISTORY_LEN-2:0], level};
      deb_in  = deb_ff;
      if (hist_in == '0) begin
         deb_in = 1'b0;
      end else if (hist_in == '1) begin
         deb_in = 1'b1;
      end
      press = deb_ff & ~deb_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '1;
         deb_ff  <= 1'b1;
      end else if (enable) begin
         hist_ff <= hist_in;
         deb_ff  <= deb_in;
      end
   end

endmodule

@@ hdl/swd_timer.sv @@
// ----------------------------------------------------------------------------
// swd_timer: run flag, prescaler and hundredths/seconds counters
// Counts are kept both in binary and as decimal digits so the display
// needs no division.
// ----------------------------------------------------------------------------
module swd_timer (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  swd_pkg::keys_type  keys,
   input  logic [7:0]         ticks_per_hundredth,
   output swd_pkg::count_type count_cur,
   output swd_pkg::count_type count_nxt
);

   swd_pkg::count_type count_ff, count_in;
   logic [7:0]         prescale_ff, prescale_in;
   logic [7:0]         prescale_sum;
   logic               hundredth_tick;
   logic               carry;

   // key actions, then prescale and count advance
   always_comb begin
      count_in       = count_ff;
      carry          = 1'b0;
      prescale_sum   = prescale_ff + 8'd1;
      hundredth_tick = (prescale_sum >= ticks_per_hundredth);
      prescale_in    = hundredth_tick ? 8'd0 : prescale_sum;

      if (keys.reset_press) begin
         count_in.run      = 1'b0;
         count_in.frac     = '0;
         count_in.sec      = '0;
         count_in.frac_bcd = '0;
         count_in.sec_bcd  = '0;
      end
      if (keys.toggle_press) begin
         count_in.run = ~count_in.run;
      end

      if (hundredth_tick && count_in.run) begin
         if (count_in.frac == swd_pkg::FRAC_LAST) begin
            count_in.frac     = '0;
            count_in.frac_bcd = '0;
            if (count_in.sec == swd_pkg::SEC_LAST) begin
               count_in.sec     = '0;
               count_in.sec_bcd = '0;
            end else begin
               count_in.sec = count_in.sec + 14'd1;
               carry        = 1'b1;
               for (int i = 0; i < 4; i++) begin
                  if (carry) begin
                     if (count_in.sec_bcd[i] == swd_pkg::BCD_NINE) begin
                        count_in.sec_bcd[i] = '0;
                     end else begin
                        count_in.sec_bcd[i] = count_in.sec_bcd[i] + 4'd1;
                        carry               = 1'b0;
                     end
                  end
               end
            end
         end else begin
            count_in.frac = count_in.frac + 7'd1;
            if (count_in.frac_bcd[0] == swd_pkg::BCD_NINE) begin
               count_in.frac_bcd[0] = '0;
               count_in.frac_bcd[1] = count_in.frac_bcd[1] + 4'd1;
            end else begin
               count_in.frac_bcd[0] = count_in.frac_bcd[0] + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         prescale_ff <= '0;
      end else if (enable) begin
         count_ff    <= count_in;
         prescale_ff <= prescale_in;
      end
   end

   assign count_cur = count_ff;
   assign count_nxt = count_in;

   // decimal digits track the binary counts
   a_frac_digits: assert property (@(posedge clock) disable iff (reset)
      {3'd0, count_ff.frac} == count_ff.frac_bcd[1] * 10 + count_ff.frac_bcd[0])
      else $error("hundredths digits out of step with binary count");

   a_sec_digits: assert property (@(posedge clock) disable iff (reset)
      count_ff.sec == (count_ff.sec_bcd[3] * 1000 + count_ff.sec_bcd[2] * 100
                       + count_ff.sec_bcd[1] * 10 + count_ff.sec_bcd[0]))
      else $error("seconds digits out of step with binary count");

   // a lone reset press leaves the watch stopped at zero
   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      (enable && keys.reset_press && !keys.toggle_press)
      |=> (!count_ff.run && count_ff.frac == '0 && count_ff.sec == '0))
      else $error("reset press did not clear the watch");

endmodule

@@ hdl/swd_display.sv @@
// ----------------------------------------------------------------------------
// swd_display: digit scan counter and segment pattern for one digit
// One digit per beat, driven from the count held before that beat.
// ----------------------------------------------------------------------------
module swd_display (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  swd_pkg::count_type                  count,
   output logic [swd_pkg::DIGIT_COUNT-1:0]     digit_select_n,
   output logic [7:0]                          segments
);

   logic [swd_pkg::SCAN_W-1:0] scan_ff, scan_in;

   assign scan_in = scan_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else if (enable) begin
         scan_ff <= scan_in;
      end
   end

   // active-low digit enable
   assign digit_select_n =
      ~({{(swd_pkg::DIGIT_COUNT-1){1'b0}}, 1'b1} << scan_ff);

   // segment pattern with leading-zero blanking on the upper seconds digits
   always_comb begin
      case (scan_ff)
         swd_pkg::POS_BLANK_0,
         swd_pkg::POS_BLANK_1: segments = swd_pkg::SEG_BLANK;
         swd_pkg::POS_SEC_THOU: begin
            segments = (count.sec_bcd[3] != '0) ? swd_pkg::font(count.sec_bcd[3])
                                                : swd_pkg::SEG_BLANK;
         end
         swd_pkg::POS_SEC_HUND: begin
            segments = (count.sec_bcd[3:2] != '0) ? swd_pkg::font(count.sec_bcd[2])
                                                  : swd_pkg::SEG_BLANK;
         end
         swd_pkg::POS_SEC_TENS: begin
            segments = (count.sec_bcd[3:1] != '0) ? swd_pkg::font(count.sec_bcd[1])
                                                  : swd_pkg::SEG_BLANK;
         end
         swd_pkg::POS_SEC_ONES: begin
            segments = swd_pkg::font(count.sec_bcd[0]) | swd_pkg::SEG_DP;
         end
         swd_pkg::POS_FRAC_TEN: segments = swd_pkg::font(count.frac_bcd[1]);
         swd_pkg::POS_FRAC_ONE: segments = swd_pkg::font(count.frac_bcd[0]);
         default:               segments = swd_pkg::SEG_BLANK;
      endcase
   end

endmodule

@@ hdl/stopwatch_with_debounce_and_display.sv @@
// ----------------------------------------------------------------------------
// stopwatch_with_debounce_and_display: stopwatch with key debounce and
// multiplexed eight-digit seven-segment output
// Each request beat is one 2 ms tick carrying both raw key levels; each
// response beat carries this tick's digit drive and the count after it.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  req_if   in   key_reset_raw, key_startstop_raw (raw levels, 0 = pressed)
//  rsp_if   out  digit_select_n, segments, running, hundredths, seconds
//  csr_if   in   ticks_per_hundredth (always ready)
//
//  One request beat per cycle while the request side is not stalled; its response is valid the next cycle.
//  All tick work is one combinational pass from state into the response
//  register, so throughput is one beat per cycle with no stalls of its own.
//  A held response stalls the request side only while rsp_if.ready is low.
//  Reset is synchronous: keys released, watch stopped at zero, prescale 5.
// ----------------------------------------------------------------------------
module stopwatch_with_debounce_and_display #(
   parameter int HISTORY_LEN = 8
) (
   input  logic          clock,
   input  logic          reset,
   swd_req_if.sink       req_if,
   swd_rsp_if.source     rsp_if,
   swd_csr_if.sink       csr_if
);

   logic                accept;
   logic [7:0]          tph_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   swd_pkg::keys_type   keys;
   swd_pkg::count_type  count_cur, count_nxt;
   logic [7:0]          sel_n, seg;

   logic [7:0]          sel_ff, seg_ff;
   logic                run_ff;
   logic [6:0]          frac_ff;
   logic [13:0]         sec_ff;

   // handshake: take a beat whenever the response slot is free or draining
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   // prescale register
   assign csr_if.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tph_ff <= swd_pkg::TPH_RESET;
      end else if (csr_if.valid) begin
         tph_ff <= csr_if.ticks_per_hundredth;
      end
   end

   // key debounce
   swd_debounce #(.HISTORY_LEN(HISTORY_LEN)) u_deb_reset (
      .clock  (clock),
      .reset  (reset),
      .enable (accept),
      .level  (req_if.key_reset_raw),
      .press  (keys.reset_press)
   );

   swd_debounce #(.HISTORY_LEN(HISTORY_LEN)) u_deb_toggle (
      .clock  (clock),
      .reset  (reset),
      .enable (accept),
      .level  (req_if.key_startstop_raw),
      .press  (keys.toggle_press)
   );

   // counters
   swd_timer u_timer (
      .clock               (clock),
      .reset               (reset),
      .enable              (accept),
      .keys                (keys),
      .ticks_per_hundredth (tph_ff),
      .count_cur           (count_cur),
      .count_nxt           (count_nxt)
   );

   // display drive from the count before this tick
   swd_display u_display (
      .clock          (clock),
      .reset          (reset),
      .enable         (accept),
      .count          (count_cur),
      .digit_select_n (sel_n),
      .segments       (seg)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sel_ff  <= sel_n;
         seg_ff  <= seg;
         run_ff  <= count_nxt.run;
         frac_ff <= count_nxt.frac;
         sec_ff  <= count_nxt.sec;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.digit_select_n = sel_ff;
   assign rsp_if.segments       = seg_ff;
   assign rsp_if.running        = run_ff;
   assign rsp_if.hundredths     = frac_ff;
   assign rsp_if.seconds        = sec_ff;

   // every accepted tick produces a response next cycle
   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_if.valid)
      else $error("accepted tick without response");

   // exactly one digit enabled in a shown response
   a_one_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> $onehot(~rsp_if.digit_select_n))
      else $error("digit select not one-hot");

   // counts stay in range
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.hundredths <= swd_pkg::FRAC_LAST
                        && rsp_if.seconds <= swd_pkg::SEC_LAST))
      else $error("count out of range");

endmodule
